// ===== src/rvde_pkg.sv =====
package rvde_pkg;

    localparam logic [6:0] OPC_LOAD    = 7'd3;
    localparam logic [6:0] OPC_OPIMM   = 7'd19;
    localparam logic [6:0] OPC_OPIMM_W = 7'd27;
    localparam logic [6:0] OPC_JALR    = 7'd103;
    localparam logic [6:0] OPC_AUIPC   = 7'd23;
    localparam logic [6:0] OPC_LUI     = 7'd55;
    localparam logic [6:0] OPC_STORE   = 7'd35;
    localparam logic [6:0] OPC_OP      = 7'd51;
    localparam logic [6:0] OPC_OP_W    = 7'd59;
    localparam logic [6:0] OPC_BRANCH  = 7'd99;
    localparam logic [6:0] OPC_JAL     = 7'd111;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Operation class chosen by the front end
    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_ALU    = 3'd1;
    localparam logic [2:0] K_MUL    = 3'd2;
    localparam logic [2:0] K_DIV    = 3'd3;
    localparam logic [2:0] K_CONST  = 3'd4;
    localparam logic [2:0] K_BRANCH = 3'd5;
    localparam logic [2:0] K_JALR   = 3'd6;

    localparam int QDEPTH = 2;
    localparam int DIV_STAGES = 32;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  f3;
        logic        alt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc;
        logic [31:0] cval;     // constant result (lui, auipc, link)
        logic [31:0] target;   // branch or jal target
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic [1:0]  mem_op;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        illegal;
    } dec_t;

    typedef struct packed {
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic [31:0] result;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        illegal;
    } res_t;

endpackage

// ===== src/rvde_decode.sv =====
module rvde_decode (
    input  logic [31:0]   instruction,
    input  logic [31:0]   pc,
    input  logic [31:0]   rs1_value,
    input  logic [31:0]   rs2_value,
    output rvde_pkg::dec_t dec
);
    import rvde_pkg::*;

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi, imms, immb, immj, immu;
    logic        ok;

    assign op = instruction[6:0];
    assign f3 = instruction[14:12];
    assign f7 = instruction[31:25];
    assign immi = {{20{instruction[31]}}, instruction[31:20]};
    assign imms = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign immb = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                   instruction[11:8], 1'b0};
    assign immj = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                   instruction[30:21], 1'b0};
    assign immu = {instruction[31:12], 12'd0};

    // Classify the instruction and prepare operands
    always_comb
    begin
        dec = '0;
        ok = 1'b1;
        dec.f3 = f3;
        dec.a = rs1_value;
        dec.b = rs2_value;
        dec.pc = pc;
        dec.target = pc + 32'd4;
        case (op)
            OPC_LOAD:
            begin
                if (f3 == 3'd3 || f3 > 3'd5) ok = 1'b0;
                dec.kind = K_CONST;
                dec.reg_write = 1'b1;
                dec.mem_op = MEM_LOAD;
                dec.mem_size = {1'b0, f3[0]} | {f3[1] & ~f3[2], 1'b0};
                dec.mem_address = rs1_value + immi;
            end
            OPC_STORE:
            begin
                if (f3 > 3'd2) ok = 1'b0;
                dec.kind = K_NONE;
                dec.mem_op = MEM_STORE;
                dec.mem_size = f3[1:0];
                dec.mem_address = rs1_value + imms;
                dec.store_data = rs2_value;
            end
            OPC_OPIMM, OPC_OPIMM_W:
            begin
                if (f3 == 3'd1 && f7 != 7'd0) ok = 1'b0;
                if (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'd32) ok = 1'b0;
                dec.kind = K_ALU;
                dec.reg_write = 1'b1;
                dec.alt = (f3 == 3'd5) && (f7 == 7'd32);
                dec.b = immi;
            end
            OPC_OP, OPC_OP_W:
            begin
                dec.reg_write = 1'b1;
                if (f7 == 7'd1)
                    dec.kind = f3[2] ? K_DIV : K_MUL;
                else if (f7 == 7'd0)
                    dec.kind = K_ALU;
                else if (f7 == 7'd32 && (f3 == 3'd0 || f3 == 3'd5))
                begin
                    dec.kind = K_ALU;
                    dec.alt = 1'b1;
                end
                else
                    ok = 1'b0;
            end
            OPC_LUI:
            begin
                dec.kind = K_CONST;
                dec.reg_write = 1'b1;
                dec.cval = immu;
            end
            OPC_AUIPC:
            begin
                dec.kind = K_CONST;
                dec.reg_write = 1'b1;
                dec.cval = pc + immu;
            end
            OPC_JAL:
            begin
                dec.kind = K_CONST;
                dec.reg_write = 1'b1;
                dec.cval = pc + 32'd4;
                dec.target = pc + immj;
            end
            OPC_JALR:
            begin
                if (f3 != 3'd0) ok = 1'b0;
                dec.kind = K_JALR;
                dec.reg_write = 1'b1;
                dec.cval = pc + 32'd4;
                dec.b = immi;
            end
            OPC_BRANCH:
            begin
                if (f3 == 3'd2 || f3 == 3'd3) ok = 1'b0;
                dec.kind = K_BRANCH;
                dec.cval = pc + 32'd4;
                dec.target = pc + immb;
            end
            default: ok = 1'b0;
        endcase
        if (!ok)
        begin
            dec = '0;
            dec.kind = K_NONE;
            dec.target = pc + 32'd4;
            dec.illegal = 1'b1;
        end
        else
            dec.dest_reg = dec.reg_write ? instruction[11:7] : 5'd0;
    end

endmodule

// ===== src/rvde_queue.sv =====
module rvde_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rvde_pkg::dec_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rvde_pkg::dec_t  out_data
);
    import rvde_pkg::*;

    dec_t       mem_reg [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'(QDEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Hold decoded items until the back end takes them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_data;
    end

endmodule

// ===== src/rvde_execute.sv =====
module rvde_execute (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rvde_pkg::dec_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rvde_pkg::res_t  out_data
);
    import rvde_pkg::*;

    localparam int NS = DIV_STAGES + 2;

    // Pipeline: stage 0 prepares, stages 1..32 one quotient bit each, last finishes
    logic        v_reg     [NS];
    res_t        r_reg     [NS];
    logic [2:0]  kind_reg  [NS];
    logic [2:0]  f3_reg    [NS];
    logic [31:0] rem_reg   [NS];
    logic [31:0] quo_reg   [NS];
    logic [31:0] dvs_reg   [NS];
    logic        negq_reg  [NS];
    logic        negr_reg  [NS];
    logic        spec_reg  [NS];
    logic [31:0] sval_reg  [NS];
    logic [63:0] prod_reg  [NS];
    logic        adv;

    logic        oval_reg;
    res_t        odat_reg;

    res_t        fin;
    logic [31:0] q, r;

    assign adv = !oval_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = oval_reg;
    assign out_data = odat_reg;

    // Stage 0 combinational work
    logic [31:0] a, b, alu, ma, mb;
    logic        lts, ltu, taken, na, nb, sgn_a, sgn_b;
    logic [32:0] sa, sb;
    logic [65:0] prod_s;
    res_t        r0;

    always_comb
    begin
        a = in_data.a;
        b = in_data.b;
        lts = $signed(a) < $signed(b);
        ltu = a < b;
        case (in_data.f3)
            3'd0: alu = in_data.alt ? a - b : a + b;
            3'd1: alu = a << b[4:0];
            3'd2: alu = {31'd0, lts};
            3'd3: alu = {31'd0, ltu};
            3'd4: alu = a ^ b;
            3'd5: alu = in_data.alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: alu = a | b;
            default: alu = a & b;
        endcase
        case (in_data.f3)
            3'd0: taken = (a == b);
            3'd1: taken = (a != b);
            3'd4: taken = lts;
            3'd5: taken = !lts;
            3'd6: taken = ltu;
            default: taken = !ltu;
        endcase
        sgn_a = (in_data.f3 == 3'd1) || (in_data.f3 == 3'd2);
        sgn_b = (in_data.f3 == 3'd1);
        sa = {sgn_a & a[31], a};
        sb = {sgn_b & b[31], b};
        prod_s = 66'($signed(sa) * $signed(sb));
        na = a[31] && !in_data.f3[0];
        nb = b[31] && !in_data.f3[0];
        ma = na ? 32'd0 - a : a;
        mb = nb ? 32'd0 - b : b;
        r0.dest_reg = in_data.dest_reg;
        r0.reg_write = in_data.reg_write;
        r0.mem_op = in_data.mem_op;
        r0.mem_size = in_data.mem_size;
        r0.mem_address = in_data.mem_address;
        r0.store_data = in_data.store_data;
        r0.illegal = in_data.illegal;
        r0.next_pc = in_data.target;
        r0.result = 32'd0;
        case (in_data.kind)
            K_ALU:    r0.result = alu;
            K_CONST:  r0.result = in_data.cval;
            K_JALR:
            begin
                r0.result = in_data.cval;
                r0.next_pc = (a + b) & ~32'd1;
            end
            K_BRANCH: r0.next_pc = taken ? in_data.target : in_data.cval;
            default:  r0.result = 32'd0;
        endcase
    end

    // One restoring division step per stage
    logic [32:0] trial [NS];
    always_comb
    begin
        for (int s = 0; s < NS; s++)
            trial[s] = '0;
        for (int s = 1; s <= DIV_STAGES; s++)
            trial[s] = {rem_reg[s-1], quo_reg[s-1][31]} - {1'b0, dvs_reg[s-1]};
    end

    // Advance the pipeline as one when the output can move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++) v_reg[s] <= 1'b0;
            oval_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) v_reg[s] <= v_reg[s-1];
            oval_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0] <= r0;
            kind_reg[0] <= in_data.kind;
            f3_reg[0] <= in_data.f3;
            rem_reg[0] <= 32'd0;
            quo_reg[0] <= ma;
            dvs_reg[0] <= mb;
            negq_reg[0] <= na ^ nb;
            negr_reg[0] <= na;
            prod_reg[0] <= prod_s[63:0];
            spec_reg[0] <= (b == 32'd0) ||
                           (!in_data.f3[0] && a == 32'h80000000 && b == 32'hFFFFFFFF);
            if (b == 32'd0)
                sval_reg[0] <= in_data.f3[1] ? a : 32'hFFFFFFFF;
            else
                sval_reg[0] <= in_data.f3[1] ? 32'd0 : 32'h80000000;
            for (int s = 1; s < NS; s++)
            begin
                r_reg[s] <= r_reg[s-1];
                kind_reg[s] <= kind_reg[s-1];
                f3_reg[s] <= f3_reg[s-1];
                dvs_reg[s] <= dvs_reg[s-1];
                negq_reg[s] <= negq_reg[s-1];
                negr_reg[s] <= negr_reg[s-1];
                prod_reg[s] <= prod_reg[s-1];
                spec_reg[s] <= spec_reg[s-1];
                sval_reg[s] <= sval_reg[s-1];
                if (s <= DIV_STAGES)
                begin
                    if (!trial[s][32])
                    begin
                        rem_reg[s] <= trial[s][31:0];
                        quo_reg[s] <= {quo_reg[s-1][30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s] <= {rem_reg[s-1][30:0], quo_reg[s-1][31]};
                        quo_reg[s] <= {quo_reg[s-1][30:0], 1'b0};
                    end
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    quo_reg[s] <= quo_reg[s-1];
                end
            end
            odat_reg <= fin;
        end
    end

    // Finish multiply and divide results
    always_comb
    begin
        fin = r_reg[NS-1];
        q = negq_reg[NS-1] ? 32'd0 - quo_reg[NS-1] : quo_reg[NS-1];
        r = negr_reg[NS-1] ? 32'd0 - rem_reg[NS-1] : rem_reg[NS-1];
        if (kind_reg[NS-1] == K_MUL)
            fin.result = (f3_reg[NS-1] == 3'd0) ? prod_reg[NS-1][31:0]
                                                : prod_reg[NS-1][63:32];
        else if (kind_reg[NS-1] == K_DIV)
        begin
            if (spec_reg[NS-1])
                fin.result = sval_reg[NS-1];
            else
                fin.result = f3_reg[NS-1][1] ? r : q;
        end
    end

endmodule

// ===== src/rv32im_decode_execute.sv =====
// Throughput: one item per cycle while the consumer takes results; the 32-step
// divider is fully pipelined, one quotient bit per stage, and every item walks
// the same stages to keep order. A two-entry queue parts decode from execute;
// the output register parts execute from the consumer. Reset (rst_n low,
// asynchronous) empties queue and pipeline.
module rv32im_decode_execute (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // instruction, pc, rs1_value, rs2_value
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata    // dest_reg, reg_write, result, next_pc, mem_op,
                                     // mem_size, mem_address, store_data, illegal, pad
);
    import rvde_pkg::*;

    dec_t dec, qd;
    res_t rs;
    logic qv, qr;

    rvde_decode u_dec (
        .instruction(s_tdata[31:0]),
        .pc(s_tdata[63:32]),
        .rs1_value(s_tdata[95:64]),
        .rs2_value(s_tdata[127:96]),
        .dec(dec)
    );

    rvde_queue u_q (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(dec),
        .out_valid(qv), .out_ready(qr), .out_data(qd)
    );

    rvde_execute u_ex (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qv), .in_ready(qr), .in_data(qd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(rs)
    );

    // Pack the result item
    assign m_tdata = {5'd0, rs.illegal, rs.store_data, rs.mem_address, rs.mem_size,
                      rs.mem_op, rs.next_pc, rs.result, rs.reg_write, rs.dest_reg};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rvde_pkg::*;

    typedef struct {
        logic [31:0] instr;
        logic [31:0] pc;
        logic [31:0] rs1;
        logic [31:0] rs2;
        bit          has_exp;
        res_t        exp_res;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [143:0]  m_tdata;

    res_t          expected_q[$];
    int            err_count;
    row_t          rows[$];

    rv32im_decode_execute u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Base integer ALU; alt selects sub or sra
    function automatic logic [31:0] int_alu(logic [2:0] f3, logic alt,
                                            logic [31:0] a, logic [31:0] b);
        case (f3)
            3'd0: return alt ? a - b : a + b;
            3'd1: return a << b[4:0];
            3'd2: return {31'd0, signed_lt(a, b)};
            3'd3: return {31'd0, a < b};
            3'd4: return a ^ b;
            3'd5: return alt ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: return a | b;
            default: return a & b;
        endcase
    endfunction

    // Multiply and divide unit
    function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (f3)
            3'd0: return a * b;
            3'd1:
            begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                return prod[63:32];
            end
            3'd2:
            begin
                prod = {{32{a[31]}}, a} * {32'd0, b};
                return prod[63:32];
            end
            3'd3:
            begin
                prod = {32'd0, a} * {32'd0, b};
                return prod[63:32];
            end
            3'd5: return (b == 0) ? 32'hFFFF_FFFF : a / b;
            3'd7: return (b == 0) ? a : a % b;
            default:
            begin
                if (b == 0)
                    return (f3 == 3'd4) ? 32'hFFFF_FFFF : a;
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                    return (f3 == 3'd4) ? 32'h8000_0000 : 32'd0;
                if (f3 == 3'd4)
                    return (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                return a[31] ? -(ma % mb) : ma % mb;
            end
        endcase
    endfunction

    // Decode and execute one instruction
    function automatic res_t execute_instr(logic [31:0] ins, logic [31:0] pc,
                                           logic [31:0] a, logic [31:0] b);
        res_t        r;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] immi;
        logic [31:0] imms;
        logic [31:0] immb;
        logic [31:0] immj;
        logic        ok;
        logic        wr;
        logic        taken;
        op = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        immi = {{20{ins[31]}}, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r = '0;
        r.next_pc = pc + 4;
        ok = 1'b1;
        wr = 1'b0;
        taken = 1'b0;
        case (op)
            OPC_LOAD:
                if (f3 == 3'd3 || f3 > 3'd5)
                    ok = 1'b0;
                else
                begin
                    wr = 1'b1;
                    r.mem_op = MEM_LOAD;
                    r.mem_size = {1'b0, f3[1:0]} == 3'd3 ? 2'd0 : f3[1:0];
                    r.mem_address = a + immi;
                end
            OPC_STORE:
                if (f3 > 3'd2)
                    ok = 1'b0;
                else
                begin
                    r.mem_op = MEM_STORE;
                    r.mem_size = f3[1:0];
                    r.mem_address = a + imms;
                    r.store_data = b;
                end
            OPC_OPIMM, OPC_OPIMM_W:
                if ((f3 == 3'd1 && f7 != 0) || (f3 == 3'd5 && f7 != 0 && f7 != 7'd32))
                    ok = 1'b0;
                else
                begin
                    wr = 1'b1;
                    r.result = int_alu(f3, f3 == 3'd5 && f7 == 7'd32, a, immi);
                end
            OPC_OP, OPC_OP_W:
            begin
                wr = 1'b1;
                if (f7 == 7'd1)
                    r.result = muldiv(f3, a, b);
                else if (f7 == 0)
                    r.result = int_alu(f3, 1'b0, a, b);
                else if (f7 == 7'd32 && (f3 == 3'd0 || f3 == 3'd5))
                    r.result = int_alu(f3, 1'b1, a, b);
                else
                    ok = 1'b0;
            end
            OPC_LUI:
            begin
                wr = 1'b1;
                r.result = {ins[31:12], 12'd0};
            end
            OPC_AUIPC:
            begin
                wr = 1'b1;
                r.result = pc + {ins[31:12], 12'd0};
            end
            OPC_JAL:
            begin
                wr = 1'b1;
                r.result = pc + 4;
                r.next_pc = pc + immj;
            end
            OPC_JALR:
                if (f3 != 0)
                    ok = 1'b0;
                else
                begin
                    wr = 1'b1;
                    r.result = pc + 4;
                    r.next_pc = (a + immi) & ~32'd1;
                end
            OPC_BRANCH:
            begin
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = signed_lt(a, b);
                    3'd5: taken = !signed_lt(a, b);
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: ok = 1'b0;
                endcase
                if (ok && taken)
                    r.next_pc = pc + immb;
            end
            default: ok = 1'b0;
        endcase
        if (!ok)
        begin
            r = '0;
            r.next_pc = pc + 4;
            r.illegal = 1'b1;
        end
        else
        begin
            r.reg_write = wr;
            r.dest_reg = wr ? ins[11:7] : 5'd0;
        end
        return r;
    endfunction

    function automatic res_t illegal_res(logic [31:0] pc);
        res_t r;
        r = '0;
        r.next_pc = pc + 4;
        r.illegal = 1'b1;
        return r;
    endfunction

    // Random instruction, mostly well-formed with random fields
    function automatic logic [31:0] rand_instr();
        logic [31:0] ins;
        logic [6:0]  opcs[11];
        int          sel;
        opcs = '{OPC_LOAD, OPC_OPIMM, OPC_OPIMM_W, OPC_JALR, OPC_AUIPC, OPC_LUI,
                 OPC_STORE, OPC_OP, OPC_OP_W, OPC_BRANCH, OPC_JAL};
        ins = $urandom;
        sel = $urandom_range(99, 0);
        if (sel < 8)
            return ins;
        ins[6:0] = opcs[$urandom_range(10, 0)];
        if (ins[6:0] == OPC_OP || ins[6:0] == OPC_OP_W || ins[6:0] == OPC_OPIMM
            || ins[6:0] == OPC_OPIMM_W)
        begin
            case ($urandom_range(9, 0))
                0, 1, 2: ins[31:25] = 7'd1;
                3, 4, 5: ins[31:25] = 7'd0;
                6, 7: ins[31:25] = 7'd32;
                default: ;
            endcase
        end
        return ins;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7, 0))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(8, 0);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus and end of run
    initial
    begin
        row_t rw;
        int   gap;
        int   burst;
        int   drain;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        err_count = 0;
        burst = 0;
        gap = 0;

        // Directed rows: illegal ones carry a typed-in result
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h7FFF_FFFF, 32'h8000_0000,
                         1'b1, illegal_res(32'hFFFF_FFFC)});
        rows.push_back('{32'h0000_0000, 32'h0, 32'h0, 32'h0, 1'b1, illegal_res(32'h0)});
        rows.push_back('{32'h0000_300F, 32'h100, 32'h0, 32'h0, 1'b1, illegal_res(32'h100)});
        rows.push_back('{32'h0000_7183, 32'h10, 32'h1, 32'h2, 1'b1,
                         illegal_res(32'h10)});
        rows.push_back('{32'h0000_3023, 32'h20, 32'h1, 32'h2, 1'b1, illegal_res(32'h20)});
        rows.push_back('{32'h0000_1067, 32'h30, 32'h1, 32'h2, 1'b1, illegal_res(32'h30)});
        rows.push_back('{32'h0000_2063, 32'h40, 32'h1, 32'h2, 1'b1, illegal_res(32'h40)});
        rows.push_back('{32'h0200_1013, 32'h50, 32'h1, 32'h2, 1'b1, illegal_res(32'h50)});
        rows.push_back('{32'h4200_0033, 32'h60, 32'h1, 32'h2, 1'b1, illegal_res(32'h60)});
        // Loads, stores, lui/auipc/jal/jalr, extremes
        rows.push_back('{32'hFFF0_4083, 32'h0, 32'h0, 32'h0, 1'b0, '0});
        rows.push_back('{32'hFE20_AFA3, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0});
        rows.push_back('{32'hFFFF_F0B7, 32'h0, 32'h0, 32'h0, 1'b0, '0});
        rows.push_back('{32'hFFFF_F017, 32'hFFFF_FFFC, 32'h0, 32'h0, 1'b0, '0});
        rows.push_back('{32'h8000_00EF, 32'h0, 32'h0, 32'h0, 1'b0, '0});
        rows.push_back('{32'hFFF0_80E7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, '0});
        // sltu/sra/srl, div by zero, signed overflow, branches
        rows.push_back('{32'h0020_B0B3, 32'h0, 32'hFFFF_FFFF, 32'h1, 1'b0, '0});
        rows.push_back('{32'h4020_D0B3, 32'h0, 32'h8000_0000, 32'h1F, 1'b0, '0});
        rows.push_back('{32'h0020_D0BB, 32'h0, 32'h8000_0000, 32'h1F, 1'b0, '0});
        rows.push_back('{32'h0220_C0B3, 32'h0, 32'h1234_5678, 32'h0, 1'b0, '0});
        rows.push_back('{32'h0220_F0B3, 32'h0, 32'h1234_5678, 32'h0, 1'b0, '0});
        rows.push_back('{32'h0220_C0B3, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0});
        rows.push_back('{32'h0220_E0B3, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0});
        rows.push_back('{32'h0220_90B3, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
        rows.push_back('{32'h8000_40E3, 32'h100, 32'hFFFF_FFFF, 32'h0, 1'b0, '0});
        rows.push_back('{32'h7E00_7FE3, 32'h100, 32'h0, 32'hFFFF_FFFF, 1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table, then random items, in bursts with gaps
        for (int i = 0; i < 1850; i++)
        begin
            if (i < rows.size())
                rw = rows[i];
            else
            begin
                rw.instr = rand_instr();
                rw.pc = $urandom;
                rw.rs1 = rand_operand();
                rw.rs2 = rand_operand();
                rw.has_exp = 1'b0;
            end
            if (burst == 0)
            begin
                burst = $urandom_range(40, 1);
                gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst--;
            s_tvalid <= 1'b1;
            s_tdata <= {rw.rs2, rw.rs1, rw.pc, rw.instr};
            expected_q.push_back(rw.has_exp ? rw.exp_res
                                 : execute_instr(rw.instr, rw.pc, rw.rs1, rw.rs2));
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (expected_q.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (err_count == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver stalls: alternate free runs and random back-pressure
    initial
    begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if ((phase / 64) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(2, 0) != 0);
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        res_t got;
        res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.dest_reg    = m_tdata[4:0];
            got.reg_write   = m_tdata[5];
            got.result      = m_tdata[37:6];
            got.next_pc     = m_tdata[69:38];
            got.mem_op      = m_tdata[71:70];
            got.mem_size    = m_tdata[73:72];
            got.mem_address = m_tdata[105:74];
            got.store_data  = m_tdata[137:106];
            got.illegal     = m_tdata[138];
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item %h", $realtime, got);
                err_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.dest_reg != exp_r.dest_reg || got.reg_write != exp_r.reg_write
                    || got.result != exp_r.result || got.next_pc != exp_r.next_pc
                    || got.mem_op != exp_r.mem_op || got.mem_size != exp_r.mem_size
                    || got.mem_address != exp_r.mem_address
                    || got.store_data != exp_r.store_data
                    || got.illegal != exp_r.illegal)
                begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
                    err_count++;
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
src/rvde_pkg.sv
src/rvde_decode.sv
src/rvde_queue.sv
src/rvde_execute.sv
src/rv32im_decode_execute.sv
verif/tb_top.sv
